// ===== src/sxfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite XOR framebuffer package
// Shared widths, operation codes, the memory request type and the sprite
// placement function.
// ----------------------------------------------------------------------------
package sxfb_pkg;

   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int LINE_W        = $clog2(SCREEN_HEIGHT);
   localparam int SPRITE_W      = 8;

   // Operation codes carried in the input tuser field.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef logic [SCREEN_WIDTH-1:0] row_type;
   typedef logic [LINE_W-1:0]       line_type;

   // Request from the control logic to the framebuffer memory.
   typedef struct packed {
      logic     rd_en;
      line_type rd_addr;
      logic     wr_en;
      line_type wr_addr;
      row_type  wr_data;
      logic     clear;
   } mem_req_type;

   // Places an 8-pixel sprite byte (bit 7 leftmost) at column x, wrapping
   // round the right-hand edge. Bit 0 of the result is column 0.
   function automatic row_type place_sprite(input logic [COL_W-1:0] x,
                                            input logic [SPRITE_W-1:0] bits);
      row_type                  rev;
      logic [2*SCREEN_WIDTH-1:0] both;
      rev = '0;
      for (int j = 0; j < SPRITE_W; j++) begin
         rev[j] = bits[SPRITE_W-1-j];
      end
      // The upper half of the doubled word shifted left is a left rotation.
      both = {rev, rev} << x;
      return both[2*SCREEN_WIDTH-1:SCREEN_WIDTH];
   endfunction

endpackage

// ===== src/sxfb_mem.sv =====
// ----------------------------------------------------------------------------
// Sprite XOR framebuffer row memory
// One framebuffer row per entry, one read and one write port, registered read
// data. A valid bit per row lets reset and screen clear empty every row at once.
// ----------------------------------------------------------------------------
module sxfb_mem
   import sxfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type req,
   output row_type     rd_data
);

   row_type                  mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] valid_ff;
   logic [SCREEN_HEIGHT-1:0] valid_in;
   row_type                  rd_data_ff;
   logic                     rd_valid_ff;

   // Row storage: write and registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff  <= mem[req.rd_addr];
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   // A row that has not been written since reset or clear reads as all off.
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/sprite_xor_framebuffer.sv =====
// ----------------------------------------------------------------------------
// Sprite XOR framebuffer
// Monochrome 64x32 framebuffer with XOR sprite row drawing, collision
// detection, screen clear and row read.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one operation per item: the op code in tuser,
//   x, y, row_index and sprite_byte in tdata and the last sprite row flag in
//   tlast. Every item gives exactly one item on the rsp_ channel: collision
//   and the 64 row pixels in tdata, sprite done in tlast.
//   A draw reads the target row from the row memory, XORs the placed sprite
//   byte into it and writes it back; a read returns the stored row.
//   Sequence: the row memory is read at the edge that accepts the item, and
//   the modify and write-back follow in the execute step; when that step
//   finishes, the result goes into the output register. No new item is
//   taken during that read-modify-write on the single row memory.
//   The result sits in an output register, so the next item is accepted
//   while it waits. If the receiver stalls with the output register full,
//   the block holds the following item in its execute step until the
//   register is freed, and accepts nothing more meanwhile.
//   Reset clears the whole screen and the collision flag at once; the block
//   accepts an item in the cycle after reset is released.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer
   import sxfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: x [7:0], y [15:8], row_index [23:16], sprite_byte [31:24]
   input  logic [31:0] req_tdata,
   // tuser: op [1:0]
   input  logic [1:0]  req_tuser,
   // tlast: last_row
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: collision [0], row_pixels [64:1], zero padding [71:65]
   output logic [71:0] rsp_tdata,
   // tlast: sprite_done
   output logic        rsp_tlast
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [1:0]           op_ff;
   logic [COL_W-1:0]     x_ff;
   logic [SPRITE_W-1:0]  sb_ff;
   line_type             line_ff;
   logic                 last_ff;
   logic                 collision_sticky_ff, collision_sticky_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_collision_ff;
   row_type              out_row_ff;
   logic                 out_last_ff;

   logic                 accept;
   logic                 finish;
   line_type             line_sum;
   line_type             line_sel;
   row_type              old_row;
   row_type              mask;
   row_type              new_row;
   logic                 hit;
   logic                 res_collision;
   row_type              res_row;
   logic                 res_last;
   mem_req_type          mem_req;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign finish     = (state_ff == S_EXEC) && (!out_valid_ff || rsp_tready);

   // Target line: wrapped start line plus row index for a draw.
   assign line_sum = req_tdata[8 +: LINE_W] + req_tdata[16 +: LINE_W];
   assign line_sel = (req_tuser == OP_DRAW) ? line_sum
                                            : req_tdata[8 +: LINE_W];

   // Modify step on the row returned by the memory.
   assign mask    = place_sprite(x_ff, sb_ff);
   assign new_row = old_row ^ mask;
   assign hit     = |(old_row & mask);

   // Result and collision flag for the item in the execute step.
   always_comb begin
      res_collision       = 1'b0;
      res_row             = '0;
      res_last            = 1'b0;
      collision_sticky_in = collision_sticky_ff;
      case (op_ff)
         OP_DRAW: begin
            res_collision = collision_sticky_ff | hit;
            res_row       = new_row;
            res_last      = last_ff;
            if (finish) begin
               collision_sticky_in = last_ff ? 1'b0 : res_collision;
            end
         end
         OP_READ: begin
            res_row = old_row;
         end
         default: begin
         end
      endcase
   end

   // Memory requests: read on accept, write back or clear on finish.
   always_comb begin
      mem_req.rd_en   = accept;
      mem_req.rd_addr = line_sel;
      mem_req.wr_en   = finish && (op_ff == OP_DRAW);
      mem_req.wr_addr = line_ff;
      mem_req.wr_data = new_row;
      mem_req.clear   = finish && (op_ff == OP_CLEAR);
   end

   sxfb_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (old_row)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register occupancy.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (finish) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         collision_sticky_ff <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         collision_sticky_ff <= collision_sticky_in;
         out_valid_ff        <= out_valid_in;
      end
   end

   // Item fields held through the execute step.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         x_ff    <= req_tdata[COL_W-1:0];
         sb_ff   <= req_tdata[31:24];
         line_ff <= line_sel;
         last_ff <= req_tlast;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (finish) begin
         out_collision_ff <= res_collision;
         out_row_ff       <= res_row;
         out_last_ff      <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_row_ff, out_collision_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== dv/sprite_xor_framebuffer_tb.sv =====
// ----------------------------------------------------------------------------
// Sprite XOR framebuffer testbench
// Drives clear, draw, read and unused operations into the block. A small
// framebuffer predictor keeps its own copy of the screen and the collision
// flag, and every result item is compared field by field with the oldest
// prediction. Both channels idle at random, and the receiver holds off once
// for a long stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer_tb;
   import sxfb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The op code that the block leaves unused.
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         RANDOM_ITEMS = 1350;
   localparam int         HOLD_CYCLES  = 300;

   // One predicted result item.
   typedef struct {
      logic    collision;
      row_type pixels;
      logic    done;
   } pixel_result_type;

   // Framebuffer predictor and store of the results still to come.
   class framebuffer_tracker;
      row_type          screen [SCREEN_HEIGHT];
      logic             sprite_hit;
      pixel_result_type pending_results [$];
      int               errors;
      int               draws;
      int               reads;
      int               clears;
      int               unused_ops;
      int               hits;
      int               sprites;

      function new();
         foreach (screen[i]) screen[i] = '0;
         sprite_hit = 1'b0;
         errors     = 0;
         draws      = 0;
         reads      = 0;
         clears     = 0;
         unused_ops = 0;
         hits       = 0;
         sprites    = 0;
      endfunction

      // Spreads the sprite byte over eight columns from col0, wrapping right.
      function row_type sprite_mask(logic [COL_W-1:0] col0, logic [7:0] bits);
         row_type          mask;
         logic [COL_W-1:0] col;
         mask = '0;
         for (int j = 0; j < 8; j++) begin
            col = col0 + COL_W'(j);
            if (bits[7-j]) mask[col] = 1'b1;
         end
         return mask;
      endfunction

      // Applies one accepted item to the screen and queues its result.
      function void note_item(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                              logic [7:0] row_index, logic [7:0] sprite_byte,
                              logic last_row);
         pixel_result_type want;
         line_type         line;
         row_type          mask;
         want = '{collision: 1'b0, pixels: '0, done: 1'b0};
         case (op)
            OP_CLEAR: begin
               foreach (screen[i]) screen[i] = '0;
               clears++;
            end
            OP_DRAW: begin
               line = y[LINE_W-1:0] + row_index[LINE_W-1:0];
               mask = sprite_mask(x[COL_W-1:0], sprite_byte);
               if ((screen[line] & mask) != '0) sprite_hit = 1'b1;
               screen[line] ^= mask;
               want.collision = sprite_hit;
               want.pixels    = screen[line];
               want.done      = last_row;
               if (sprite_hit) hits++;
               if (last_row) begin
                  sprite_hit = 1'b0;
                  sprites++;
               end
               draws++;
            end
            OP_READ: begin
               want.pixels = screen[y[LINE_W-1:0]];
               reads++;
            end
            default: begin
               unused_ops++;
            end
         endcase
         pending_results.push_back(want);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      // Compares one accepted result item with the oldest prediction.
      task check_result(logic [71:0] data, logic done);
         pixel_result_type want;
         if (pending_results.size() == 0) begin
            report("result item arrived with nothing expected");
            return;
         end
         want = pending_results.pop_front();
         if (data[0] !== want.collision)
            report($sformatf("collision %b, expected %b", data[0], want.collision));
         if (data[64:1] !== want.pixels)
            report($sformatf("row pixels %h, expected %h", data[64:1], want.pixels));
         if (data[71:65] !== '0)
            report($sformatf("padding bits %h are not zero", data[71:65]));
         if (done !== want.done)
            report($sformatf("sprite done %b, expected %b", done, want.done));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_CLEAR;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   framebuffer_tracker tracker = new();
   int                 items_sent = 0;
   int                 cycles     = 0;
   bit                 calm       = 1'b0;
   bit                 held_off   = 1'b0;

   sprite_xor_framebuffer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offers one item, with random idle cycles first, and waits for it to go.
   task send_item(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                  logic [7:0] row_index, logic [7:0] sprite_byte, logic last_row);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sprite_byte, row_index, y, x};
      req_tlast  <= last_row;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // A well-formed sprite: same origin, rising row index, last on the final row.
   task send_sprite();
      logic [7:0] x;
      logic [7:0] y;
      int         rows;
      x    = 8'($urandom_range(255));
      y    = 8'($urandom_range(255));
      rows = $urandom_range(1, 15);
      for (int r = 0; r < rows; r++) begin
         if ($urandom_range(99) < 10)
            send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         send_item(OP_DRAW, x, y, 8'(r), 8'($urandom), r == rows - 1);
      end
   endtask

   // Both channels are watched at the same edge the block uses.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_item(req_tuser, req_tdata[7:0], req_tdata[15:8],
                              req_tdata[23:16], req_tdata[31:24], req_tlast);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: random stalls, one long hold-off, and a calm stretch.
   initial begin
      int hold_left;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!held_off && items_sent >= 400) begin
            held_off   = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 16);
         end
         @(posedge clock);
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, tracker.pending_results.size());
      $display("sprite_xor_framebuffer_tb failed");
      $finish;
   end

   // Main stimulus and end of run.
   initial begin
      int start_count;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, wrapping, collision across a clear, unused op.
      send_item(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(OP_CLEAR,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(OP_DRAW,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
      send_item(OP_DRAW,   8'h40, 8'h20, 8'h00, 8'h80, 1'b1);
      send_item(OP_DRAW,   8'h3C, 8'h1F, 8'h01, 8'hAA, 1'b1);
      send_item(OP_DRAW,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_item(OP_DRAW,   8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
      send_item(OP_READ,   8'hFF, 8'hFE, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_READ,   8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
      send_item(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      // A sprite that collides, is interrupted by a clear, then ends.
      send_item(OP_DRAW,   8'h3F, 8'h00, 8'h00, 8'h01, 1'b0);
      send_item(OP_DRAW,   8'h3F, 8'h00, 8'h00, 8'h01, 1'b0);
      send_item(OP_CLEAR,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_DRAW,   8'h3F, 8'h00, 8'h01, 8'h55, 1'b1);
      send_item(OP_DRAW,   8'h3F, 8'h00, 8'h01, 8'h55, 1'b0);
      send_item(OP_DRAW,   8'h3F, 8'h00, 8'h02, 8'hC3, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(OP_READ,   8'h00, 8'h01, 8'h00, 8'h00, 1'b0);
      send_item(OP_DRAW,   8'h80, 8'h80, 8'h80, 8'hFF, 1'b1);
      send_item(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

      // Random part: mostly whole sprites, with reads, clears and noise.
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         calm = (items_sent - start_count >= 700) && (items_sent - start_count < 900);
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_sprite();
         end else if (pick < 84) begin
            send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end else if (pick < 88) begin
            send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end else if (pick < 90) begin
            send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end else begin
            // Broken sprite rows: any index, last flag at random.
            send_item(OP_DRAW, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // Drain, then allow a few cycles for any stray result.
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report("results still expected at the end of the run");

      $display("Covered %0d draws over %0d sprites, %0d reads, %0d clears, %0d unused ops.",
               tracker.draws, tracker.sprites, tracker.reads, tracker.clears,
               tracker.unused_ops);
      $display("Saw %0d draw results with collision set; %0d mismatches.",
               tracker.hits, tracker.errors);
      if (tracker.errors == 0) begin
         $display("sprite_xor_framebuffer_tb passed");
      end else begin
         $display("sprite_xor_framebuffer_tb failed");
      end
      $finish;
   end

endmodule

// ===== sprite_xor_framebuffer.f =====
src/sxfb_pkg.sv
src/sxfb_mem.sv
src/sprite_xor_framebuffer.sv
dv/sprite_xor_framebuffer_tb.sv
